[design/gdpr_pkg.sv]
// types and constants for the gps dle packet receiver
// shared by the top level and the port checker; depends on nothing
package gdpr_pkg;

  // framing bytes and packet ids
  localparam logic [7:0] B_DLE      = 8'h10;
  localparam logic [7:0] B_ETX      = 8'h03;
  localparam logic [7:0] ID_TIME    = 8'h41;
  localparam logic [7:0] ID_VERSION = 8'h45;
  localparam logic [7:0] ID_HEALTH  = 8'h46;
  localparam logic [7:0] ID_LLA     = 8'h4A;
  localparam logic [7:0] HLT_RESET  = 8'h02;
  localparam logic [3:0] NIB_SHORT  = 4'h3;
  localparam logic [3:0] NIB_OPEN   = 4'h1;

  localparam int PAYLOAD_MAX = 12;
  localparam logic [3:0] PAYLOAD_MAX_C = 4'd12;

  // host opcodes
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TIME  = 2'd2;
  localparam logic [1:0] OP_POS   = 2'd3;

  // link modes
  localparam logic [2:0] M_PREINIT = 3'd0;
  localparam logic [2:0] M_RESET   = 3'd1;
  localparam logic [2:0] M_SEARCH  = 3'd2;
  localparam logic [2:0] M_READY   = 3'd3;
  localparam logic [2:0] M_QUERY   = 3'd4;

  // fault codes
  localparam logic [2:0] F_OK      = 3'd0;
  localparam logic [2:0] F_RESET   = 3'd1;
  localparam logic [2:0] F_SHORT   = 3'd2;
  localparam logic [2:0] F_OPEN    = 3'd3;
  localparam logic [2:0] F_BATTERY = 3'd4;

  // commands to transmit
  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_RESET  = 3'd1;
  localparam logic [2:0] CMD_TIME   = 3'd2;
  localparam logic [2:0] CMD_POS    = 3'd3;
  localparam logic [2:0] CMD_HEALTH = 3'd4;

  // query status
  localparam logic [2:0] QS_NONE     = 3'd0;
  localparam logic [2:0] QS_REJECTED = 3'd1;
  localparam logic [2:0] QS_ACCEPTED = 3'd2;
  localparam logic [2:0] QS_OK       = 3'd3;
  localparam logic [2:0] QS_FAILED   = 3'd4;

  // deframer phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ID   = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_ESC  = 2'd3;

  // pending query kind
  localparam logic [1:0] PK_NONE = 2'd0;
  localparam logic [1:0] PK_TIME = 2'd1;
  localparam logic [1:0] PK_POS  = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
    logic       with_reset;
  } gdpr_in_t;

  typedef struct packed {
    logic [2:0]  link_state;
    logic [2:0]  fault_code;
    logic [2:0]  send_command;
    logic [2:0]  query_status;
    logic        packet_done;
    logic [7:0]  packet_id;
    logic        frame_error;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic [15:0] week_number;
  } gdpr_out_t;

endpackage

[design/gps_dle_packet_receiver_top.sv]
// gps receiver link: dle/etx deframer, link state, fault and query tracking; uses gdpr_pkg
// path: an accepted beat goes through the input register and then the result register;
// a result beat held by out_stall can keep the next beat waiting in the input register
// throughput: one beat per cycle; input stalls only while a result beat is held by out_stall
// reset: rst_n synchronous, active low; clears both stages and returns the link to
// pre-init, fault ok, no query pending, deframer idle, payload zero
module gps_dle_packet_receiver_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gdpr_pkg::gdpr_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gdpr_pkg::gdpr_out_t out_data
);

  // pipeline registers
  logic                s1_vld_r;
  gdpr_pkg::gdpr_in_t  s1_data_r;
  logic                out_vld_r;
  gdpr_pkg::gdpr_out_t out_data_r;
  logic                s1_go;

  // link and deframer state
  logic [2:0] mode_r, mode_nxt;
  logic [2:0] fault_r, fault_nxt;
  logic [1:0] pend_r, pend_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [7:0] id_r, id_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [7:0] pay_r [gdpr_pkg::PAYLOAD_MAX];
  logic [7:0] pay_nxt [gdpr_pkg::PAYLOAD_MAX];
  gdpr_pkg::gdpr_out_t res_nxt;

  // handshake: stage one moves when the result register is free or drained
  assign s1_go     = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = s1_vld_r && !s1_go;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_vld_r <= 1'b1;
    end else if (s1_go) begin
      s1_vld_r <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  // per-beat state update and result
  always_comb begin
    logic [7:0] b;
    logic       start_pkt;
    logic       store;
    logic       close_pkt;
    logic [7:0] s0;
    logic [7:0] s1;

    mode_nxt  = mode_r;
    fault_nxt = fault_r;
    pend_nxt  = pend_r;
    phase_nxt = phase_r;
    id_nxt    = id_r;
    cnt_nxt   = cnt_r;
    pay_nxt   = pay_r;
    res_nxt   = '0;
    b         = s1_data_r.rx_byte;
    start_pkt = 1'b0;
    store     = 1'b0;
    close_pkt = 1'b0;
    s0        = pay_r[0];
    s1        = pay_r[1];

    case (s1_data_r.opcode)
      gdpr_pkg::OP_BYTE: begin
        // deframer
        if (mode_r != gdpr_pkg::M_PREINIT) begin
          case (phase_r)
            gdpr_pkg::PH_IDLE: begin
              if (b == gdpr_pkg::B_DLE) phase_nxt = gdpr_pkg::PH_ID;
            end
            gdpr_pkg::PH_ID: begin
              if (b == gdpr_pkg::B_ETX) begin
                res_nxt.frame_error = 1'b1;
                phase_nxt = gdpr_pkg::PH_IDLE;
              end else if (b == gdpr_pkg::B_DLE) begin
                res_nxt.frame_error = 1'b1;
              end else begin
                start_pkt = 1'b1;
              end
            end
            gdpr_pkg::PH_DATA: begin
              if (b == gdpr_pkg::B_DLE) phase_nxt = gdpr_pkg::PH_ESC;
              else store = 1'b1;
            end
            default: begin
              if (b == gdpr_pkg::B_DLE) begin
                store = 1'b1;
                phase_nxt = gdpr_pkg::PH_DATA;
              end else if (b == gdpr_pkg::B_ETX) begin
                phase_nxt = gdpr_pkg::PH_IDLE;
                close_pkt = 1'b1;
              end else begin
                res_nxt.frame_error = 1'b1;
                start_pkt = 1'b1;
              end
            end
          endcase
        end
      end
      gdpr_pkg::OP_START: begin
        // start fails any pending query
        if (pend_r != gdpr_pkg::PK_NONE) begin
          res_nxt.query_status = gdpr_pkg::QS_FAILED;
          pend_nxt = gdpr_pkg::PK_NONE;
        end
        if (s1_data_r.with_reset) begin
          res_nxt.send_command = gdpr_pkg::CMD_RESET;
          mode_nxt = gdpr_pkg::M_RESET;
        end else begin
          res_nxt.send_command = gdpr_pkg::CMD_HEALTH;
          mode_nxt = gdpr_pkg::M_SEARCH;
        end
      end
      default: begin
        // time or position request
        if (mode_r != gdpr_pkg::M_READY || pend_r != gdpr_pkg::PK_NONE) begin
          res_nxt.query_status = gdpr_pkg::QS_REJECTED;
        end else begin
          res_nxt.query_status = gdpr_pkg::QS_ACCEPTED;
          mode_nxt = gdpr_pkg::M_QUERY;
          if (s1_data_r.opcode == gdpr_pkg::OP_TIME) begin
            res_nxt.send_command = gdpr_pkg::CMD_TIME;
            pend_nxt = gdpr_pkg::PK_TIME;
          end else begin
            res_nxt.send_command = gdpr_pkg::CMD_POS;
            pend_nxt = gdpr_pkg::PK_POS;
          end
        end
      end
    endcase

    // open a new packet: clear the payload
    if (start_pkt) begin
      id_nxt    = b;
      cnt_nxt   = '0;
      phase_nxt = gdpr_pkg::PH_DATA;
      for (int i = 0; i < gdpr_pkg::PAYLOAD_MAX; i++) pay_nxt[i] = '0;
    end

    // keep the first twelve payload bytes
    if (store && cnt_r < gdpr_pkg::PAYLOAD_MAX_C) begin
      pay_nxt[cnt_r] = b;
      cnt_nxt = cnt_r + 4'd1;
    end

    // closed packet: health, link transitions, query replies
    if (close_pkt) begin
      res_nxt.packet_done = 1'b1;
      res_nxt.packet_id   = id_r;
      if (id_r == gdpr_pkg::ID_HEALTH) begin
        if (s0 == gdpr_pkg::HLT_RESET) begin
          res_nxt.send_command = gdpr_pkg::CMD_RESET;
          if (pend_nxt != gdpr_pkg::PK_NONE) begin
            res_nxt.query_status = gdpr_pkg::QS_FAILED;
            pend_nxt = gdpr_pkg::PK_NONE;
          end
          fault_nxt = gdpr_pkg::F_RESET;
          mode_nxt  = gdpr_pkg::M_RESET;
        end else begin
          fault_nxt = gdpr_pkg::F_OK;
        end
        if (s1[7:4] == gdpr_pkg::NIB_SHORT) fault_nxt = gdpr_pkg::F_SHORT;
        else if (s1[7:4] == gdpr_pkg::NIB_OPEN) fault_nxt = gdpr_pkg::F_OPEN;
        else if (s1[0]) fault_nxt = gdpr_pkg::F_BATTERY;
      end

      case (mode_nxt)
        gdpr_pkg::M_RESET: begin
          if (id_r == gdpr_pkg::ID_VERSION) mode_nxt = gdpr_pkg::M_SEARCH;
        end
        gdpr_pkg::M_SEARCH: begin
          if (id_r == gdpr_pkg::ID_HEALTH && s0 == 8'd0) mode_nxt = gdpr_pkg::M_READY;
        end
        gdpr_pkg::M_READY: begin
          if (id_r == gdpr_pkg::ID_HEALTH && s0 != 8'd0) mode_nxt = gdpr_pkg::M_SEARCH;
        end
        gdpr_pkg::M_QUERY: begin
          if (id_r == gdpr_pkg::ID_HEALTH && s0 != 8'd0) begin
            mode_nxt = gdpr_pkg::M_SEARCH;
            if (pend_nxt != gdpr_pkg::PK_NONE) begin
              res_nxt.query_status = gdpr_pkg::QS_FAILED;
              pend_nxt = gdpr_pkg::PK_NONE;
            end
          end else if (id_r == gdpr_pkg::ID_TIME && pend_nxt == gdpr_pkg::PK_TIME) begin
            res_nxt.word_a       = {pay_r[0], pay_r[1], pay_r[2], pay_r[3]};
            res_nxt.week_number  = {pay_r[4], pay_r[5]};
            res_nxt.word_b       = {pay_r[6], pay_r[7], pay_r[8], pay_r[9]};
            res_nxt.query_status = gdpr_pkg::QS_OK;
            pend_nxt = gdpr_pkg::PK_NONE;
            mode_nxt = gdpr_pkg::M_READY;
          end else if (id_r == gdpr_pkg::ID_LLA && pend_nxt == gdpr_pkg::PK_POS) begin
            res_nxt.word_a       = {pay_r[0], pay_r[1], pay_r[2], pay_r[3]};
            res_nxt.word_b       = {pay_r[4], pay_r[5], pay_r[6], pay_r[7]};
            res_nxt.word_c       = {pay_r[8], pay_r[9], pay_r[10], pay_r[11]};
            res_nxt.query_status = gdpr_pkg::QS_OK;
            pend_nxt = gdpr_pkg::PK_NONE;
            mode_nxt = gdpr_pkg::M_READY;
          end
        end
        default: begin
        end
      endcase
    end

    res_nxt.link_state = mode_nxt;
    res_nxt.fault_code = fault_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= gdpr_pkg::M_PREINIT;
      fault_r <= gdpr_pkg::F_OK;
      pend_r  <= gdpr_pkg::PK_NONE;
      phase_r <= gdpr_pkg::PH_IDLE;
      id_r    <= '0;
      cnt_r   <= '0;
      for (int i = 0; i < gdpr_pkg::PAYLOAD_MAX; i++) pay_r[i] <= '0;
    end else if (s1_go) begin
      mode_r  <= mode_nxt;
      fault_r <= fault_nxt;
      pend_r  <= pend_nxt;
      phase_r <= phase_nxt;
      id_r    <= id_nxt;
      cnt_r   <= cnt_nxt;
      pay_r   <= pay_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_go) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
    if (s1_go) begin
      out_data_r <= res_nxt;
    end
  end

endmodule

[design/gdpr_checker.sv]
// port checker for the gps dle packet receiver, bound to the top level
// uses gdpr_pkg for codes and beat types
module gdpr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input gdpr_pkg::gdpr_out_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // a closed packet never also flags a framing error
  a_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.packet_done && out_data.frame_error))
    else $error("packet done and frame error together");

  // reply words only come with a completed query
  a_words_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.query_status != gdpr_pkg::QS_OK |->
      out_data.word_a == 32'd0 && out_data.word_b == 32'd0 &&
      out_data.word_c == 32'd0 && out_data.week_number == 16'd0)
    else $error("reply words without completed query");

  // a completed query leaves the link ready
  a_ok_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.query_status == gdpr_pkg::QS_OK |->
      out_data.link_state == gdpr_pkg::M_READY)
    else $error("completed query but link not ready");

  // a time or position request puts the link in query mode
  a_cmd_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.send_command == gdpr_pkg::CMD_TIME ||
                  out_data.send_command == gdpr_pkg::CMD_POS) |->
      out_data.link_state == gdpr_pkg::M_QUERY &&
      out_data.query_status == gdpr_pkg::QS_ACCEPTED)
    else $error("query command without query mode");

endmodule

bind gps_dle_packet_receiver_top gdpr_checker u_gdpr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[verif/tb_top.sv]
// self-checking bench for gps_dle_packet_receiver_top: drives receiver bytes and
// host events, predicts each result beat and compares it field by field
// depends on gdpr_pkg and the top level only
module tb_top;

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 6;

  // tracks link, fault, query and deframer state; holds result beats due
  class link_tracker;
    logic [2:0] mode;
    logic [2:0] fault;
    logic [1:0] query_kind;
    logic [1:0] phase;
    logic [7:0] open_id;
    logic [3:0] count;
    logic [7:0] body [gdpr_pkg::PAYLOAD_MAX];
    gdpr_pkg::gdpr_out_t due [$];
    int errors;
    int beats;
    int packets;
    int answered;

    function new();
      mode = gdpr_pkg::M_PREINIT;
      fault = gdpr_pkg::F_OK;
      query_kind = gdpr_pkg::PK_NONE;
      phase = gdpr_pkg::PH_IDLE;
      open_id = 8'h00;
      count = 4'd0;
      foreach (body[i]) body[i] = 8'h00;
      errors = 0;
      beats = 0;
      packets = 0;
      answered = 0;
    endfunction

    function void drop_query(inout gdpr_pkg::gdpr_out_t r);
      if (query_kind != gdpr_pkg::PK_NONE) begin
        r.query_status = gdpr_pkg::QS_FAILED;
        query_kind = gdpr_pkg::PK_NONE;
      end
    endfunction

    function void open_packet(logic [7:0] id);
      open_id = id;
      count = 4'd0;
      foreach (body[i]) body[i] = 8'h00;
      phase = gdpr_pkg::PH_DATA;
    endfunction

    function void keep_byte(logic [7:0] b);
      if (count < gdpr_pkg::PAYLOAD_MAX_C) begin
        body[count] = b;
        count++;
      end
    endfunction

    // one accepted input beat: update state, queue the result it causes
    function void take_event(gdpr_pkg::gdpr_in_t ev);
      gdpr_pkg::gdpr_out_t r;
      logic [7:0] b;
      logic [7:0] s0;
      logic [7:0] b1;
      r = '0;
      b = ev.rx_byte;
      if (ev.opcode == gdpr_pkg::OP_BYTE) begin
        if (mode != gdpr_pkg::M_PREINIT) begin
          case (phase)
            gdpr_pkg::PH_IDLE: if (b == gdpr_pkg::B_DLE) phase = gdpr_pkg::PH_ID;
            gdpr_pkg::PH_ID: begin
              if (b == gdpr_pkg::B_ETX) begin
                r.frame_error = 1'b1;
                phase = gdpr_pkg::PH_IDLE;
              end else if (b == gdpr_pkg::B_DLE) begin
                r.frame_error = 1'b1;
              end else begin
                open_packet(b);
              end
            end
            gdpr_pkg::PH_DATA: begin
              if (b == gdpr_pkg::B_DLE) phase = gdpr_pkg::PH_ESC;
              else keep_byte(b);
            end
            default: begin
              if (b == gdpr_pkg::B_DLE) begin
                keep_byte(b);
                phase = gdpr_pkg::PH_DATA;
              end else if (b == gdpr_pkg::B_ETX) begin
                // packet closed
                phase = gdpr_pkg::PH_IDLE;
                r.packet_done = 1'b1;
                r.packet_id = open_id;
                packets++;
                s0 = body[0];
                b1 = body[1];
                if (open_id == gdpr_pkg::ID_HEALTH) begin
                  if (s0 == gdpr_pkg::HLT_RESET) begin
                    r.send_command = gdpr_pkg::CMD_RESET;
                    drop_query(r);
                    fault = gdpr_pkg::F_RESET;
                    mode = gdpr_pkg::M_RESET;
                  end else begin
                    fault = gdpr_pkg::F_OK;
                  end
                  if (b1[7:4] == gdpr_pkg::NIB_SHORT) fault = gdpr_pkg::F_SHORT;
                  else if (b1[7:4] == gdpr_pkg::NIB_OPEN) fault = gdpr_pkg::F_OPEN;
                  else if (b1[0]) fault = gdpr_pkg::F_BATTERY;
                end
                case (mode)
                  gdpr_pkg::M_RESET:
                    if (open_id == gdpr_pkg::ID_VERSION) mode = gdpr_pkg::M_SEARCH;
                  gdpr_pkg::M_SEARCH:
                    if (open_id == gdpr_pkg::ID_HEALTH && s0 == 8'h00) mode = gdpr_pkg::M_READY;
                  gdpr_pkg::M_READY:
                    if (open_id == gdpr_pkg::ID_HEALTH && s0 != 8'h00) mode = gdpr_pkg::M_SEARCH;
                  gdpr_pkg::M_QUERY: begin
                    if (open_id == gdpr_pkg::ID_HEALTH && s0 != 8'h00) begin
                      mode = gdpr_pkg::M_SEARCH;
                      drop_query(r);
                    end else if (open_id == gdpr_pkg::ID_TIME &&
                                 query_kind == gdpr_pkg::PK_TIME) begin
                      r.word_a = {body[0], body[1], body[2], body[3]};
                      r.week_number = {body[4], body[5]};
                      r.word_b = {body[6], body[7], body[8], body[9]};
                      r.query_status = gdpr_pkg::QS_OK;
                      query_kind = gdpr_pkg::PK_NONE;
                      mode = gdpr_pkg::M_READY;
                      answered++;
                    end else if (open_id == gdpr_pkg::ID_LLA &&
                                 query_kind == gdpr_pkg::PK_POS) begin
                      r.word_a = {body[0], body[1], body[2], body[3]};
                      r.word_b = {body[4], body[5], body[6], body[7]};
                      r.word_c = {body[8], body[9], body[10], body[11]};
                      r.query_status = gdpr_pkg::QS_OK;
                      query_kind = gdpr_pkg::PK_NONE;
                      mode = gdpr_pkg::M_READY;
                      answered++;
                    end
                  end
                  default: ;
                endcase
              end else begin
                // stray dle: open packet dropped, byte is the new id
                r.frame_error = 1'b1;
                open_packet(b);
              end
            end
          endcase
        end
      end else if (ev.opcode == gdpr_pkg::OP_START) begin
        drop_query(r);
        if (ev.with_reset) begin
          r.send_command = gdpr_pkg::CMD_RESET;
          mode = gdpr_pkg::M_RESET;
        end else begin
          r.send_command = gdpr_pkg::CMD_HEALTH;
          mode = gdpr_pkg::M_SEARCH;
        end
      end else begin
        // time or position request
        if (mode != gdpr_pkg::M_READY || query_kind != gdpr_pkg::PK_NONE) begin
          r.query_status = gdpr_pkg::QS_REJECTED;
        end else begin
          r.send_command = (ev.opcode == gdpr_pkg::OP_TIME) ?
                           gdpr_pkg::CMD_TIME : gdpr_pkg::CMD_POS;
          query_kind = (ev.opcode == gdpr_pkg::OP_TIME) ?
                       gdpr_pkg::PK_TIME : gdpr_pkg::PK_POS;
          mode = gdpr_pkg::M_QUERY;
          r.query_status = gdpr_pkg::QS_ACCEPTED;
        end
      end
      r.link_state = mode;
      r.fault_code = fault;
      due.push_back(r);
      beats++;
    endfunction

    function bit differs(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // one accepted result beat against the oldest one due
    function void check_report(gdpr_pkg::gdpr_out_t got);
      gdpr_pkg::gdpr_out_t want;
      bit bad;
      if (due.size() == 0) begin
        $display("%0t: result beat with none due, expected nothing, actual %h", $time, got);
        errors++;
        return;
      end
      want = due.pop_front();
      bad = 1'b0;
      bad |= differs("link_state", 32'(want.link_state), 32'(got.link_state));
      bad |= differs("fault_code", 32'(want.fault_code), 32'(got.fault_code));
      bad |= differs("send_command", 32'(want.send_command), 32'(got.send_command));
      bad |= differs("query_status", 32'(want.query_status), 32'(got.query_status));
      bad |= differs("packet_done", 32'(want.packet_done), 32'(got.packet_done));
      bad |= differs("packet_id", 32'(want.packet_id), 32'(got.packet_id));
      bad |= differs("frame_error", 32'(want.frame_error), 32'(got.frame_error));
      bad |= differs("word_a", want.word_a, got.word_a);
      bad |= differs("word_b", want.word_b, got.word_b);
      bad |= differs("word_c", want.word_c, got.word_c);
      bad |= differs("week_number", 32'(want.week_number), 32'(got.week_number));
      if (bad) errors++;
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  gdpr_pkg::gdpr_in_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  gdpr_pkg::gdpr_out_t out_data;

  link_tracker        tracker;
  gdpr_pkg::gdpr_in_t script [$];
  logic [7:0]         frame_body [$];
  int tx_gap_pct = 27;
  int rx_hold_pct = 56;
  int quiet_cycles = 0;

  gps_dle_packet_receiver_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver side stalls at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_hold_pct);
  end

  // result beats are checked at the falling edge, before the accepting edge
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_report(out_data);
  end

  // watchdog on cycles where neither channel moves a beat
  always @(negedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function void add_byte(logic [7:0] b);
    gdpr_pkg::gdpr_in_t item;
    item = '0;
    item.opcode = gdpr_pkg::OP_BYTE;
    item.rx_byte = b;
    item.with_reset = 1'($urandom);
    script.push_back(item);
  endfunction

  function void add_op(logic [1:0] op, logic with_reset);
    gdpr_pkg::gdpr_in_t item;
    item = '0;
    item.opcode = op;
    item.rx_byte = 8'($urandom);
    item.with_reset = with_reset;
    script.push_back(item);
  endfunction

  // framed packet from frame_body, dle bytes doubled
  function void add_packet(logic [7:0] id);
    add_byte(gdpr_pkg::B_DLE);
    add_byte(id);
    foreach (frame_body[i]) begin
      add_byte(frame_body[i]);
      if (frame_body[i] == gdpr_pkg::B_DLE) add_byte(gdpr_pkg::B_DLE);
    end
    add_byte(gdpr_pkg::B_DLE);
    add_byte(gdpr_pkg::B_ETX);
  endfunction

  // byte with framing values and extremes weighted up
  function logic [7:0] pick_byte();
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) return gdpr_pkg::B_DLE;
    if (roll < 25) return gdpr_pkg::B_ETX;
    if (roll < 30) return 8'h00;
    if (roll < 35) return 8'hFF;
    return 8'($urandom);
  endfunction

  // one random chunk of traffic: mostly well-formed packets and requests
  function void plan_burst();
    int roll;
    int len;
    logic [7:0] id;
    roll = $urandom_range(99);
    if (roll < 55) begin
      case ($urandom_range(9))
        0, 1, 2: id = gdpr_pkg::ID_HEALTH;
        3:       id = gdpr_pkg::ID_VERSION;
        4, 5:    id = gdpr_pkg::ID_TIME;
        6, 7:    id = gdpr_pkg::ID_LLA;
        default: id = 8'($urandom);
      endcase
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 20) : $urandom_range(0, 12);
      frame_body.delete();
      for (int i = 0; i < len; i++) frame_body.push_back(pick_byte());
      if (id == gdpr_pkg::ID_HEALTH && len > 0) begin
        case ($urandom_range(4))
          0, 1:    frame_body[0] = 8'h00;
          2:       frame_body[0] = gdpr_pkg::HLT_RESET;
          default: ;
        endcase
        if (len > 1) begin
          case ($urandom_range(4))
            0:       frame_body[1] = {gdpr_pkg::NIB_SHORT, 4'($urandom)};
            1:       frame_body[1] = {gdpr_pkg::NIB_OPEN, 4'($urandom)};
            2:       frame_body[1] = {4'h0, 3'($urandom), 1'b1};
            3:       frame_body[1] = 8'h00;
            default: ;
          endcase
        end
      end
      add_packet(id);
    end else if (roll < 75) begin
      add_op(($urandom_range(1) == 0) ? gdpr_pkg::OP_TIME : gdpr_pkg::OP_POS, 1'($urandom));
    end else if (roll < 80) begin
      add_op(gdpr_pkg::OP_START, 1'($urandom));
    end else if (roll < 90) begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) add_byte(8'($urandom));
    end else begin
      // broken frame: lead dle, then framing-heavy bytes, no closing dle etx appended
      add_byte(gdpr_pkg::B_DLE);
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) add_byte(pick_byte());
    end
  endfunction

  // present one beat until the block takes it
  task automatic send_event(input gdpr_pkg::gdpr_in_t ev);
    bit took;
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    tracker.take_event(ev);
  endtask

  task automatic play_script();
    while (script.size() != 0) send_event(script.pop_front());
  endtask

  // hold off the sender until every result due has come
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.due.size() != 0);
  endtask

  task automatic run_traffic(input int beats);
    int sent;
    sent = 0;
    while (sent < beats) begin
      plan_burst();
      sent += script.size();
      play_script();
    end
  endtask

  initial begin
    tracker = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: byte before start, query before ready, reset start
    add_byte(gdpr_pkg::B_DLE);
    add_op(gdpr_pkg::OP_TIME, 1'b0);
    add_op(gdpr_pkg::OP_START, 1'b1);
    frame_body.delete();
    add_packet(gdpr_pkg::ID_VERSION);
    // bad lead byte, then etx in the id slot
    add_byte(8'hFF);
    add_byte(gdpr_pkg::B_DLE);
    add_byte(gdpr_pkg::B_ETX);
    // dle in the id slot, then a clean health packet brings the link up
    add_byte(gdpr_pkg::B_DLE);
    frame_body.delete();
    frame_body.push_back(8'h00);
    frame_body.push_back(8'h00);
    add_packet(gdpr_pkg::ID_HEALTH);
    // accepted query, second query rejected, start with query pending
    add_op(gdpr_pkg::OP_POS, 1'b0);
    add_op(gdpr_pkg::OP_TIME, 1'b1);
    add_op(gdpr_pkg::OP_START, 1'b0);
    // stray dle in payload opens a health packet that asks for reset
    add_byte(gdpr_pkg::B_DLE);
    add_byte(gdpr_pkg::ID_HEALTH);
    add_byte(gdpr_pkg::B_DLE);
    add_byte(gdpr_pkg::ID_HEALTH);
    add_byte(gdpr_pkg::HLT_RESET);
    add_byte(gdpr_pkg::B_DLE);
    add_byte(gdpr_pkg::B_ETX);
    play_script();

    run_traffic(280);
    settle();
    tx_gap_pct = 56;
    rx_hold_pct = 27;
    run_traffic(285);
    settle();
    tx_gap_pct = 0;
    rx_hold_pct = 0;
    run_traffic(285);
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d beats: %0d closed packets, %0d answered queries",
             tracker.beats, tracker.packets, tracker.answered);
    if (tracker.errors == 0 && tracker.due.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d failing beats, %0d results never arrived",
               tracker.errors, tracker.due.size());
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
